// ----- hdl/mp2d_pkg.sv -----
`default_nettype none

package mp2d_pkg;

    // Register field widths
    localparam int IMG_W      = 7;
    localparam int WIN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Stream payload widths
    localparam int PIX_W      = 32;
    localparam int IDX_OUT_W  = 6;
    localparam int M_DATA_W   = 48;
    localparam int M_PAD_W    = M_DATA_W - PIX_W - 2 * IDX_OUT_W;

    // Divider lanes: one for the row axis, one for the column axis
    localparam int DIV_LANES  = 2;
    localparam int LANE_ROW   = 0;
    localparam int LANE_COL   = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    // Control for the compare unit
    typedef struct packed {
        logic valid;
        logic first;
    } cmp_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/max_pool_2d.sv -----
// Streaming 2-D max pooling over a square signed image in raster order.
// Each accepted pixel first waits on the serial divider that finds the stride phase; a pixel
// that closes a window then scans it with one line-store read per window pixel and waits
// for a free output register. A new pixel is taken only in idle, once the last is through.
// Reset: async, active low; registers 64 / 3 / 1, position row 0, column 0; store not cleared.
`default_nettype none

module max_pool_2d import mp2d_pkg::*; #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_WINDOW = 8,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [31:0] pixel
    input  wire logic                  s_tuser,   // [0] frame_start
    // pooled output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [31:0] pooled, [37:32] out_row,
                                                  // [43:38] out_col, [47:44] zero
    output logic                       m_tlast    // last result of the image
);

    // position width, arithmetic width for compares, line-store geometry
    localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW     = ((POS_W > WIN_W) ? POS_W : WIN_W) + 2;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW     = SLOT_W + 1;
    localparam int DEPTH  = MAX_WINDOW * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // line-store address: row slot times row pitch plus column
    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0]  col);
        store_addr = ADDR_W'(slot) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
    endfunction

    // next slot with wrap at MAX_WINDOW
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        slot_inc = (SW'(slot) + 1'b1 >= SW'(MAX_WINDOW)) ? '0 : slot + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [IMG_W-1:0] image_side_reg;
    logic [WIN_W-1:0] window_side_reg;
    logic [WIN_W-1:0] step_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_side_reg  <= 7'd64;
            window_side_reg <= 4'd3;
            step_size_reg   <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_SIDE:  image_side_reg  <= cfg_data;
                REG_WINDOW_SIDE: window_side_reg <= cfg_data[WIN_W-1:0];
                REG_STEP_SIZE:   step_size_reg   <= cfg_data[WIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // saturate registers into their legal ranges
    logic [AW-1:0]    side_c;
    logic [WIN_W-1:0] win_c;
    logic [WIN_W-1:0] step_c;

    always_comb
    begin
        if (image_side_reg == '0)
            side_c = AW'(1);
        else if (32'(image_side_reg) > MAX_SIDE)
            side_c = AW'(MAX_SIDE);
        else
            side_c = AW'(image_side_reg);

        if (window_side_reg == '0)
            win_c = WIN_W'(1);
        else if (32'(window_side_reg) > MAX_WINDOW)
            win_c = WIN_W'(MAX_WINDOW);
        else
            win_c = window_side_reg;

        if (step_size_reg == '0)
            step_c = WIN_W'(1);
        else if (32'(step_size_reg) > MAX_WINDOW)
            step_c = WIN_W'(MAX_WINDOW);
        else
            step_c = step_size_reg;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    seq_state_t state_reg;
    seq_state_t state_next;

    logic div_done;
    logic emit_hit;
    logic scan_end;
    logic out_free;

    // sequencer outputs
    logic accept;
    logic in_scan;
    logic load_out;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = emit_hit ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        in_scan  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  in_scan  = 1'b1;
            ST_EMIT:  load_out = out_free;
            default:  ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // position tracking (done at the request of each pixel)
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  row_pos_reg,  row_pos_next;
    logic [POS_W-1:0]  col_pos_reg,  col_pos_next;
    logic [SLOT_W-1:0] row_slot_reg, row_slot_next;   // row_pos mod MAX_WINDOW

    logic              restart;
    logic [POS_W-1:0]  r_eff;
    logic [POS_W-1:0]  c_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic [AW-1:0]     r1;
    logic [AW-1:0]     c1;
    logic [AW-1:0]     win_a;
    logic [AW-1:0]     top_a;
    logic [AW-1:0]     left_a;
    logic              emit_ok;
    logic              last_ok;

    always_comb
    begin
        // frame start or a position outside a shrunk image restarts at the corner
        restart  = s_tuser || (AW'(row_pos_reg) >= side_c) || (AW'(col_pos_reg) >= side_c);
        r_eff    = restart ? '0 : row_pos_reg;
        c_eff    = restart ? '0 : col_pos_reg;
        slot_eff = restart ? '0 : row_slot_reg;

        r1     = AW'(r_eff) + 1'b1;
        c1     = AW'(c_eff) + 1'b1;
        win_a  = AW'(win_c);
        top_a  = r1 - win_a;
        left_a = c1 - win_a;

        // window fits and this pixel is its bottom-right corner
        emit_ok = (r1 >= win_a) && (c1 >= win_a) && (win_a <= side_c);
        // no further window start on either axis: final result of the image
        last_ok = (top_a + AW'(step_c) + win_a > side_c) &&
                  (left_a + AW'(step_c) + win_a > side_c);

        // advance the raster position
        if (c1 >= side_c)
        begin
            col_pos_next = '0;
            if (r1 >= side_c)
            begin
                row_pos_next  = '0;
                row_slot_next = '0;
            end
            else
            begin
                row_pos_next  = POS_W'(r1);
                row_slot_next = slot_inc(slot_eff);
            end
        end
        else
        begin
            col_pos_next  = POS_W'(c1);
            row_pos_next  = r_eff;
            row_slot_next = slot_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            row_slot_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            row_slot_reg <= row_slot_next;
        end
    end

    // per-pixel context held for the window scan
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [POS_W-1:0]  left_reg;
    logic [WIN_W-1:0]  win_reg;
    logic              emit_ok_reg;
    logic              last_ok_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_slot_reg <= slot_eff;
            left_reg     <= POS_W'(left_a);
            win_reg      <= win_c;
            emit_ok_reg  <= emit_ok;
            last_ok_reg  <= last_ok;
        end
    end

    // ------------------------------------------------------------------
    // stride phase and pooled index: top / step and left / step
    // ------------------------------------------------------------------
    logic [DIV_LANES-1:0][POS_W-1:0] div_dividend;
    logic [DIV_LANES-1:0][POS_W-1:0] div_quot;
    logic [DIV_LANES-1:0][WIN_W-1:0] div_rem;

    always_comb
    begin
        div_dividend[LANE_ROW] = POS_W'(top_a);
        div_dividend[LANE_COL] = POS_W'(left_a);
    end

    mp2d_div #(
        .N (POS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (div_dividend),
        .divisor   (step_c),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // both offsets on a stride step
    assign emit_hit = emit_ok_reg && (div_rem[LANE_ROW] == '0) && (div_rem[LANE_COL] == '0);

    // ------------------------------------------------------------------
    // window scan: one line-store read per cycle, row by row
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]  i_cnt_reg;
    logic [WIN_W-1:0]  j_cnt_reg;
    logic [SLOT_W-1:0] scan_slot_reg;
    logic [SW-1:0]     wm1_s;
    logic [SW-1:0]     cur_s;
    logic [SLOT_W-1:0] slot_top;
    logic              last_j;
    logic              last_i;
    logic              rd_pending_reg;
    logic              first_pending_reg;

    always_comb
    begin
        // slot of the window's top row, wrapping back through the line store
        wm1_s = SW'(win_reg - 1'b1);
        cur_s = SW'(cur_slot_reg);
        if (cur_s >= wm1_s)
            slot_top = SLOT_W'(cur_s - wm1_s);
        else
            slot_top = SLOT_W'(cur_s + SW'(MAX_WINDOW) - wm1_s);

        last_j   = (j_cnt_reg == win_reg - 1'b1);
        last_i   = (i_cnt_reg == win_reg - 1'b1);
        scan_end = last_i && last_j;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVIDE)
        begin
            i_cnt_reg     <= '0;
            j_cnt_reg     <= '0;
            scan_slot_reg <= slot_top;
        end
        else if (in_scan)
        begin
            if (last_j)
            begin
                j_cnt_reg     <= '0;
                i_cnt_reg     <= i_cnt_reg + 1'b1;
                scan_slot_reg <= slot_inc(scan_slot_reg);
            end
            else
            begin
                j_cnt_reg <= j_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pending_reg    <= 1'b0;
            first_pending_reg <= 1'b0;
        end
        else
        begin
            rd_pending_reg    <= in_scan;
            first_pending_reg <= in_scan && (i_cnt_reg == '0) && (j_cnt_reg == '0);
        end
    end

    // line store: pixel written at its request, window read during the scan
    logic [PIXEL_BITS-1:0] rd_data;

    mp2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (store_addr(slot_eff, c_eff)),
        .wr_data (s_tdata[PIXEL_BITS-1:0]),
        .rd_en   (in_scan),
        .rd_addr (store_addr(scan_slot_reg, left_reg + POS_W'(j_cnt_reg))),
        .rd_data (rd_data)
    );

    // compare unit
    cmp_ctl_t                cmp_ctl;
    logic signed [PIXEL_BITS-1:0] best;

    always_comb
    begin
        cmp_ctl.valid = rd_pending_reg;
        cmp_ctl.first = first_pending_reg;
    end

    mp2d_max #(
        .WIDTH (PIXEL_BITS)
    ) u_max (
        .clk  (clk),
        .ctl  (cmp_ctl),
        .data (rd_data),
        .best (best)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    logic [PIX_W-1:0]     pooled_reg;
    logic [IDX_OUT_W-1:0] out_row_reg;
    logic [IDX_OUT_W-1:0] out_col_reg;
    logic                 last_reg;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pooled_reg  <= PIX_W'(best);       // sign-extended
            out_row_reg <= IDX_OUT_W'(div_quot[LANE_ROW]);
            out_col_reg <= IDX_OUT_W'(div_quot[LANE_COL]);
            last_reg    <= last_ok_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_col_reg, out_row_reg, pooled_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- hdl/mp2d_ram.sv -----
`default_nettype none

module mp2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mp2d_div.sv -----
`default_nettype none

// Two-lane restoring divider, one quotient bit per lane per cycle.
module mp2d_div import mp2d_pkg::*; #(
    parameter int N = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [DIV_LANES-1:0][N-1:0]     dividend,
    input  wire logic [WIN_W-1:0]                divisor,
    output logic                                 done,
    output logic      [DIV_LANES-1:0][N-1:0]     quotient,
    output logic      [DIV_LANES-1:0][WIN_W-1:0] remainder
);

    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIN_W-1:0] divisor_reg;

    logic [DIV_LANES-1:0][N-1:0]     num_reg;
    logic [DIV_LANES-1:0][WIN_W-1:0] rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    for (genvar k = 0; k < DIV_LANES; k++)
    begin : g_lane
        logic [WIN_W:0]   trial;
        logic [WIN_W:0]   diff;
        logic             fits;
        logic [WIN_W-1:0] rem_next;
        logic [N-1:0]     num_next;

        always_comb
        begin
            trial    = {rem_reg[k], num_reg[k][N-1]};
            diff     = trial - {1'b0, divisor_reg};
            fits     = (trial >= {1'b0, divisor_reg});
            rem_next = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            num_next = N'({num_reg[k], fits});
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                num_reg[k] <= dividend[k];
                rem_reg[k] <= '0;
            end
            else if (busy_reg)
            begin
                num_reg[k] <= num_next;
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hdl/mp2d_max.sv -----
`default_nettype none

// Running signed maximum over a stream of read words.
module mp2d_max import mp2d_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire cmp_ctl_t                ctl,
    input  wire logic signed [WIDTH-1:0] data,
    output logic signed      [WIDTH-1:0] best
);

    logic signed [WIDTH-1:0] best_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            if (ctl.first || (data > best_reg))
            begin
                best_reg <= data;
            end
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire
